// ----- rtl/ffrra_pkg.sv -----
// ffrra_pkg: shared constants and controller/datapath interface types
// for the first-fit row-run allocator; no dependencies
`default_nettype none

package ffrra_pkg;

    localparam int ROWS        = 8;
    localparam int COLS        = 16;
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W       = (COLS > 1) ? $clog2(COLS) : 1;

    localparam int MODE_W      = 1;
    localparam int LEN_W       = 5;
    localparam int SEL_W       = 3;
    localparam int PRICE_W     = 16;
    localparam int GROW_W      = 3;
    localparam int GSTART_W    = 4;
    localparam int COST_W      = 20;
    localparam int BITS_W      = 16;
    localparam int PROD_W      = LEN_W + PRICE_W;

    localparam logic [PRICE_W-1:0] PRICE_RESET = PRICE_W'(1000);
    localparam logic [COST_W-1:0]  COST_MAX    = {COST_W{1'b1}};

    localparam logic [MODE_W-1:0]  MODE_ALLOC  = 1'b0;
    localparam logic [MODE_W-1:0]  MODE_READ   = 1'b1;

    typedef struct packed {
        logic cap;
        logic step;
        logic grant;
        logic read;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_read;
        logic in_len_ok;
        logic found;
        logic last_row;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/ffrra_dp.sv -----
// ffrra_dp: occupancy map, row pointer, run finder, cost multiplier
// and output word registers; depends on ffrra_pkg
`default_nettype none

module ffrra_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  ffrra_pkg::t_cmd                  i_cmd,
    output ffrra_pkg::t_sts                  o_sts,
    input  wire [ffrra_pkg::MODE_W-1:0]      i_mode,
    input  wire [ffrra_pkg::LEN_W-1:0]       i_run_length,
    input  wire [ffrra_pkg::SEL_W-1:0]       i_row_select,
    input  wire                              i_price_we,
    input  wire [ffrra_pkg::PRICE_W-1:0]     i_price,
    output logic                             o_granted,
    output logic [ffrra_pkg::GROW_W-1:0]     o_grant_row,
    output logic [ffrra_pkg::GSTART_W-1:0]   o_grant_start,
    output logic [ffrra_pkg::COST_W-1:0]     o_total_cost_cents,
    output logic [ffrra_pkg::BITS_W-1:0]     o_row_bits
);
    import ffrra_pkg::*;

    typedef struct packed {
        logic             found;
        logic [COL_W-1:0] start;
        logic [COLS-1:0]  mask;
    } t_find;

    function automatic t_find find_run(input logic [COLS-1:0] row,
                                       input logic [LEN_W-1:0] len);
        t_find           res;
        logic [COLS-1:0] win;
        int              len_i;
        res   = '0;
        len_i = int'(len);
        for (int s = COLS - 1; s >= 0; s--) begin
            for (int k = 0; k < COLS; k++) begin
                win[k] = (k >= s) && (k < s + len_i);
            end
            if ((s + len_i <= COLS) && ((row & win) == '0)) begin
                res.found = 1'b1;
                res.start = COL_W'(s);
                res.mask  = win;
            end
        end
        return res;
    endfunction

    logic [COLS-1:0]    r_map [ROWS];
    logic [PRICE_W-1:0] r_price;
    logic [LEN_W-1:0]   r_len;
    logic               r_sel_ok;
    logic [ROW_W-1:0]   r_ptr;
    logic [PROD_W-1:0]  r_prod;
    logic               r_granted;
    logic [ROW_W-1:0]   r_grow;
    logic [COL_W-1:0]   r_gstart;
    logic [COLS-1:0]    r_bits;

    logic [COLS-1:0]    cur_row;
    t_find              fnd;
    logic [COST_W-1:0]  cost_sat;

    assign cur_row = r_map[r_ptr];
    assign fnd     = find_run(cur_row, r_len);

    assign o_sts.in_read   = (i_mode == MODE_READ);
    assign o_sts.in_len_ok = (i_run_length != '0) && (int'(i_run_length) <= COLS);
    assign o_sts.found     = fnd.found;
    assign o_sts.last_row  = (r_ptr == ROW_W'(ROWS - 1));

    assign cost_sat = (r_prod > PROD_W'(COST_MAX)) ? COST_MAX : r_prod[COST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_map[r] <= '0;
            end
            r_price <= PRICE_RESET;
        end else begin
            if (i_price_we) begin
                r_price <= i_price;
            end
            if (i_cmd.grant) begin
                r_map[r_ptr] <= cur_row | fnd.mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_len) * PROD_W'(r_price);
        if (i_cmd.cap) begin
            r_len     <= i_run_length;
            r_sel_ok  <= (int'(i_row_select) < ROWS);
            r_ptr     <= (i_mode == MODE_READ) ? ROW_W'(i_row_select) : '0;
            r_granted <= 1'b0;
            r_grow    <= '0;
            r_gstart  <= '0;
            r_bits    <= '0;
        end
        if (i_cmd.step) begin
            r_ptr <= r_ptr + ROW_W'(1);
        end
        if (i_cmd.grant) begin
            r_granted <= 1'b1;
            r_grow    <= r_ptr;
            r_gstart  <= fnd.start;
        end
        if (i_cmd.read) begin
            r_bits <= r_sel_ok ? cur_row : '0;
        end
        if (i_cmd.out_load) begin
            o_granted          <= r_granted;
            o_grant_row        <= GROW_W'(r_grow);
            o_grant_start      <= GSTART_W'(r_gstart);
            o_total_cost_cents <= r_granted ? cost_sat : '0;
            o_row_bits         <= BITS_W'(r_bits);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ffrra_ctrl.sv -----
// ffrra_ctrl: sequencing state machine and output word valid flag
// for the allocator; depends on ffrra_pkg
`default_nettype none

module ffrra_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    input  ffrra_pkg::t_sts i_sts,
    output ffrra_pkg::t_cmd o_cmd
);
    import ffrra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_READ = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   out_free;

    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.cap = 1'b1;
                    if (i_sts.in_read) begin
                        n_state = S_READ;
                    end else if (!i_sts.in_len_ok) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.found) begin
                    o_cmd.grant = 1'b1;
                    n_state     = S_FIN;
                end else if (i_sts.last_row) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // never overwrite a word that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output word overwritten while stalled");

    a_grant_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.grant && o_cmd.step))
        else $error("grant and step together");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("idle right after accepting a word");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("output valid dropped while stalled");

endmodule

`default_nettype wire

// ----- rtl/first_fit_row_run_allocator_core.sv -----
// first_fit_row_run_allocator_core: top level of the first-fit row-run allocator
// allocate scans one row per cycle (bad length skips the scan)
// throughput: one word at a time; next word accepted once the result is queued
// the output register lets a new word enter while the last result is stalled
// reset: synchronous active low, map cleared at once, unit price set to 1000
// depends on ffrra_pkg, ffrra_ctrl, ffrra_dp
`default_nettype none

module first_fit_row_run_allocator_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire [ffrra_pkg::MODE_W-1:0]      i_mode,
    input  wire [ffrra_pkg::LEN_W-1:0]       i_run_length,
    input  wire [ffrra_pkg::SEL_W-1:0]       i_row_select,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic                             o_granted,
    output logic [ffrra_pkg::GROW_W-1:0]     o_grant_row,
    output logic [ffrra_pkg::GSTART_W-1:0]   o_grant_start,
    output logic [ffrra_pkg::COST_W-1:0]     o_total_cost_cents,
    output logic [ffrra_pkg::BITS_W-1:0]     o_row_bits,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [ffrra_pkg::PRICE_W-1:0]     i_cfg_data
);
    import ffrra_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    ffrra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ffrra_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_mode             (i_mode),
        .i_run_length       (i_run_length),
        .i_row_select       (i_row_select),
        .i_price_we         (i_cfg_valid && o_cfg_ready),
        .i_price            (i_cfg_data),
        .o_granted          (o_granted),
        .o_grant_row        (o_grant_row),
        .o_grant_start      (o_grant_start),
        .o_total_cost_cents (o_total_cost_cents),
        .o_row_bits         (o_row_bits)
    );

endmodule

`default_nettype wire

// ----- bench/tb_first_fit_row_run_allocator_core.sv -----
`timescale 1ns / 1ps
// tb_first_fit_row_run_allocator_core: self-checking bench for the first-fit row-run allocator
// drives allocate/read words and price writes, predicts each result from its own slot map
// depends on ffrra_pkg and first_fit_row_run_allocator_core

module tb_first_fit_row_run_allocator_core;
    import ffrra_pkg::*;

    localparam int STALL_PCT  = 12;
    localparam int HOLD_LEN   = 300;
    localparam int DEAD_LIMIT = 2000;

    typedef struct packed {
        logic                granted;
        logic [GROW_W-1:0]   row;
        logic [GSTART_W-1:0] start;
        logic [COST_W-1:0]   cost;
        logic [BITS_W-1:0]   bits;
    } t_alloc_reply;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_stall;
    logic [MODE_W-1:0]   i_mode       = MODE_ALLOC;
    logic [LEN_W-1:0]    i_run_length = '0;
    logic [SEL_W-1:0]    i_row_select = '0;
    logic                o_out_valid;
    logic                i_out_stall  = 1'b0;
    logic                o_granted;
    logic [GROW_W-1:0]   o_grant_row;
    logic [GSTART_W-1:0] o_grant_start;
    logic [COST_W-1:0]   o_total_cost_cents;
    logic [BITS_W-1:0]   o_row_bits;
    logic                i_cfg_valid  = 1'b0;
    logic                o_cfg_ready;
    logic [PRICE_W-1:0]  i_cfg_data   = '0;

    logic [COLS-1:0]     slot_map [ROWS];
    logic [PRICE_W-1:0]  slot_price;
    t_alloc_reply        replies_due [$];
    t_alloc_reply        want;

    logic                quiet       = 1'b0;
    int                  hold_req    = 0;
    int                  hold_seen   = 0;
    int                  hold_left   = 0;
    int                  mismatches  = 0;
    int                  dead_cycles = 0;

    first_fit_row_run_allocator_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_mode             (i_mode),
        .i_run_length       (i_run_length),
        .i_row_select       (i_row_select),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_granted          (o_granted),
        .o_grant_row        (o_grant_row),
        .o_grant_start      (o_grant_start),
        .o_total_cost_cents (o_total_cost_cents),
        .o_row_bits         (o_row_bits),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_alloc_reply predict_reply(input logic [MODE_W-1:0] mode,
                                                   input logic [LEN_W-1:0] len,
                                                   input logic [SEL_W-1:0] sel);
        t_alloc_reply      r;
        int                run;
        int                first;
        logic [PROD_W-1:0] prod;
        r = '0;
        if (mode == MODE_READ) begin
            if (sel < ROWS)
                r.bits = BITS_W'(slot_map[sel]);
            return r;
        end
        if (len == 0 || len > COLS)
            return r;
        for (int row = 0; row < ROWS; row++) begin
            run = 0;
            for (int col = 0; col < COLS; col++) begin
                if (!slot_map[row][col]) begin
                    run++;
                    if (run == len) begin
                        first = col + 1 - int'(len);
                        for (int k = first; k <= col; k++)
                            slot_map[row][k] = 1'b1;
                        prod = PROD_W'(len) * PROD_W'(slot_price);
                        r.granted = 1'b1;
                        r.row     = GROW_W'(row);
                        r.start   = GSTART_W'(first);
                        r.cost    = (prod > COST_MAX) ? COST_MAX : prod[COST_W-1:0];
                        return r;
                    end
                end else begin
                    run = 0;
                end
            end
        end
        return r;
    endfunction

    task automatic issue_request(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] len,
                                 input logic [SEL_W-1:0] sel);
        if (!quiet && $urandom_range(99) < STALL_PCT) begin
            i_in_valid   <= 1'b0;
            i_mode       <= MODE_W'($urandom);
            i_run_length <= LEN_W'($urandom);
            i_row_select <= SEL_W'($urandom);
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_run_length <= len;
        i_row_select <= sel;
        do @(posedge i_clk); while (o_in_stall);
        replies_due.push_back(predict_reply(mode, len, sel));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_price(input logic [PRICE_W-1:0] price);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= price;
        do @(posedge i_clk); while (!o_cfg_ready);
        slot_price   = price;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        issue_request(MODE_READ, '0, 3'd0);
        issue_request(MODE_ALLOC, LEN_W'(0), SEL_W'($urandom));
        issue_request(MODE_ALLOC, LEN_W'(COLS + 1), SEL_W'($urandom));
        issue_request(MODE_ALLOC, '1, SEL_W'($urandom));
        issue_request(MODE_READ, '1, 3'd0);
        issue_request(MODE_ALLOC, LEN_W'(16), SEL_W'($urandom));
        issue_request(MODE_ALLOC, LEN_W'(1), SEL_W'($urandom));
        issue_request(MODE_ALLOC, LEN_W'(16), SEL_W'($urandom));
        issue_request(MODE_ALLOC, LEN_W'(15), SEL_W'($urandom));
        issue_request(MODE_ALLOC, LEN_W'(3), SEL_W'($urandom));
        issue_request(MODE_ALLOC, LEN_W'(13), SEL_W'($urandom));
        issue_request(MODE_ALLOC, LEN_W'(1), SEL_W'($urandom));
        issue_request(MODE_ALLOC, LEN_W'(2), SEL_W'($urandom));
        for (int r = 0; r < 5; r++)
            issue_request(MODE_READ, LEN_W'($urandom), SEL_W'(r));
        issue_request(MODE_READ, LEN_W'($urandom), SEL_W'(ROWS - 1));
    endtask

    task automatic test_backpressure();
        quiet    <= 1'b1;
        hold_req <= hold_req + 1;
        for (int n = 0; n < 16; n++)
            issue_request(n[0] ? MODE_READ : MODE_ALLOC, LEN_W'($urandom_range(1, 4)),
                          SEL_W'(n));
        quiet <= 1'b0;
    endtask

    task automatic test_random_traffic();
        int                 pick;
        logic [PRICE_W-1:0] price;
        logic [LEN_W-1:0]   len;
        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0: begin
                    price = '1;
                end
                2: begin
                    price = '0;
                end
                4: begin
                    price = PRICE_W'(1);
                end
                default: begin
                    price = PRICE_W'($urandom);
                end
            endcase
            set_price(price);
            quiet <= (seg == 3);
            for (int n = 0; n < 250; n++) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    issue_request(MODE_READ, LEN_W'($urandom), SEL_W'($urandom));
                end else begin
                    if (pick < 55)
                        len = $urandom_range(1) ? LEN_W'(0) : LEN_W'($urandom_range(COLS + 1, 31));
                    else if ($urandom_range(4) == 0)
                        len = LEN_W'($urandom_range(1, 2));
                    else
                        len = LEN_W'($urandom_range(3, COLS));
                    issue_request(MODE_ALLOC, len, SEL_W'($urandom));
                end
            end
        end
        quiet <= 1'b0;
    endtask

    task automatic test_no_room();
        for (int n = 0; n < ROWS * COLS; n++)
            issue_request(MODE_ALLOC, LEN_W'(1), SEL_W'($urandom));
        issue_request(MODE_ALLOC, LEN_W'(1), SEL_W'($urandom));
        issue_request(MODE_ALLOC, LEN_W'(COLS), SEL_W'($urandom));
        for (int r = 0; r < ROWS; r++)
            issue_request(MODE_READ, LEN_W'($urandom), SEL_W'(r));
    endtask

    // receiver stall, with a long hold when one is requested
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        i_out_stall <= (hold_left != 0) || (!quiet && $urandom_range(99) < STALL_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                if (o_granted !== want.granted) begin
                    $error("granted: expected %0d, got %0d", want.granted, o_granted);
                    mismatches++;
                end
                if (o_grant_row !== want.row) begin
                    $error("grant_row: expected %0d, got %0d", want.row, o_grant_row);
                    mismatches++;
                end
                if (o_grant_start !== want.start) begin
                    $error("grant_start: expected %0d, got %0d", want.start, o_grant_start);
                    mismatches++;
                end
                if (o_total_cost_cents !== want.cost) begin
                    $error("total_cost_cents: expected %0d, got %0d", want.cost,
                           o_total_cost_cents);
                    mismatches++;
                end
                if (o_row_bits !== want.bits) begin
                    $error("row_bits: expected %h, got %h", want.bits, o_row_bits);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                dead_cycles = 0;
            else
                dead_cycles++;
            if (dead_cycles >= DEAD_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        for (int r = 0; r < ROWS; r++)
            slot_map[r] = '0;
        slot_price = PRICE_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random_traffic();
        test_no_room();

        wait_idle();
        repeat (12) @(posedge i_clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
